// File: design/spi_touchscreen_adc_model_unit_assert.svh
// assertion macros for the touchscreen adc block
`ifndef SPI_TOUCHSCREEN_ADC_MODEL_UNIT_ASSERT_SVH
`define SPI_TOUCHSCREEN_ADC_MODEL_UNIT_ASSERT_SVH

// checked property, masked while reset is high
`define TSC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("touchscreen adc assertion failed");

// checked property, also checked across reset
`define TSC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("touchscreen adc assertion failed");

`endif

// File: design/tsc_adc_pkg.sv
package tsc_adc_pkg;

   localparam int QUEUE_DEPTH = 8;
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      MODE_SPI       = 2'd0,
      MODE_TOUCH     = 2'd1,
      MODE_TICK      = 2'd2,
      MODE_SPI_RESET = 2'd3
   } mode_type;

   // register index (address bit 2)
   localparam logic REG_TEMP1 = 1'b0;
   localparam logic REG_TAP   = 1'b1;

   // adc channel codes
   localparam logic [2:0] CH_Y     = 3'd1;
   localparam logic [2:0] CH_X     = 3'd5;
   localparam logic [2:0] CH_AUX8  = 3'd6;
   localparam logic [2:0] CH_TEMP1 = 3'd7;

   localparam logic [11:0] PEN_UP_READING  = 12'hFFF;
   localparam logic [7:0]  AUX_READING     = 8'd0;
   localparam logic [11:0] TEMP1_RESET     = 12'd142;
   localparam logic [15:0] TAP_TICKS_RESET = 16'd512;
   localparam logic [11:0] COORD_MIN       = 12'd16;
   localparam logic [11:0] X_MAX           = 12'd4080;
   localparam logic [11:0] Y_MAX           = 12'd3056;

   typedef struct packed {
      logic             we0;
      logic [PTR_W-1:0] addr0;
      logic [7:0]       data0;
      logic             we1;
      logic [PTR_W-1:0] addr1;
      logic [7:0]       data1;
   } qwr_type;

   typedef struct packed {
      logic pop;
      logic overflow;
      logic pen_up;
      logic select;
   } s0_info_type;

   function automatic logic [PTR_W-1:0] wrap_ptr(input logic [SUM_W-1:0] s);
      logic [SUM_W-1:0] d;
      d = (s >= SUM_W'(QUEUE_DEPTH)) ? s - SUM_W'(QUEUE_DEPTH) : s;
      return d[PTR_W-1:0];
   endfunction

   function automatic logic [11:0] clamp_coord(input logic [7:0] pix,
                                               input logic [11:0] hi);
      logic [11:0] v;
      v = {pix, 4'b0000};
      if (v < COORD_MIN) v = COORD_MIN;
      if (v > hi) v = hi;
      return v;
   endfunction

endpackage

// File: design/spi_touchscreen_adc_model_unit.sv
// touchscreen adc behind an spi port, one transaction in, one transaction out
// req channel: tuser carries the mode (spi byte, touch update, tick,
//   spi reset), tdata carries the spi control byte and touch fields
// rsp channel: one transaction per request with the spi read register, the
//   pen-up flag, the chip select state and the queue overflow flag
// csr port: apb-style, temp1 reading at 0x0, tap release ticks at 0x4
// the byte queue sits in a two-bank synchronous ram, read in the cycle after
//   the pop is decided; queue pointers and touch state update at acceptance
// path: a request is registered in the second stage, then in the response register
// throughput: one request per cycle while the receiver does not stall, set by
//   the single ram read port and the read register update in the second stage
// reset: queue empty, read register 0, pen up, select inactive, no valid
//   response; csr registers return to 142 and 512
// receiver stall: the response register holds; one more request is taken
//   into the second stage, then req_tready drops until rsp_tready returns
module spi_touchscreen_adc_model_unit (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: spi_byte[7:0], keep_select[8], touch_x[16:9], touch_y[24:17],
   //   pen_down[25], quick_tap[26], move_only[27], zero[31:28]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [31:0]                        req_tdata,
   // req_tuser: mode[1:0]
   input  logic [1:0]                         req_tuser,
   // rsp_tdata: read_data[7:0], pen_up_flag[8], select_active[9],
   //   queue_overflow[10], zero[15:11]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [15:0]                        rsp_tdata,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [tsc_adc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tsc_adc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tsc_adc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                               csr_pready
);

   logic                            accept;
   logic                            in_ready;
   logic [11:0]                     temp1_reading;
   logic [15:0]                     tap_release_ticks;
   tsc_adc_pkg::qwr_type            wr;
   logic                            rd_en;
   logic [tsc_adc_pkg::PTR_W-1:0]   rd_addr;
   logic [7:0]                      rd_data;
   tsc_adc_pkg::s0_info_type        s0;

   assign req_tready = in_ready;
   assign accept     = req_tvalid && in_ready;
   assign csr_pready = 1'b1;

   tsc_adc_csr u_csr (
      .clock             (clock),
      .reset             (reset),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .temp1_reading     (temp1_reading),
      .tap_release_ticks (tap_release_ticks)
   );

   // first stage: queue pointers, touch state, ram write and read issue
   tsc_adc_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .mode              (req_tuser),
      .spi_byte          (req_tdata[7:0]),
      .keep_select       (req_tdata[8]),
      .touch_x           (req_tdata[16:9]),
      .touch_y           (req_tdata[24:17]),
      .pen_down          (req_tdata[25]),
      .quick_tap         (req_tdata[26]),
      .move_only         (req_tdata[27]),
      .temp1_reading     (temp1_reading),
      .tap_release_ticks (tap_release_ticks),
      .wr                (wr),
      .rd_en             (rd_en),
      .rd_addr           (rd_addr),
      .s0                (s0)
   );

   tsc_adc_queue_ram u_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // second stage: read register update, then the response register
   tsc_adc_out u_out (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .s0         (s0),
      .rd_data    (rd_data),
      .in_ready   (in_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: design/tsc_adc_csr.sv
module tsc_adc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [tsc_adc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [tsc_adc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [tsc_adc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic [11:0]                          temp1_reading,
   output logic [15:0]                          tap_release_ticks
);

   logic [11:0] temp1_ff;
   logic [15:0] tap_ff;
   logic        reg_idx;
   logic        wr_en;

   assign reg_idx = csr_paddr[2];
   assign wr_en   = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp1_ff <= tsc_adc_pkg::TEMP1_RESET;
         tap_ff   <= tsc_adc_pkg::TAP_TICKS_RESET;
      end else if (wr_en) begin
         unique case (reg_idx)
            tsc_adc_pkg::REG_TEMP1: temp1_ff <= csr_pwdata[11:0];
            tsc_adc_pkg::REG_TAP:   tap_ff   <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         tsc_adc_pkg::REG_TEMP1: csr_prdata = {20'd0, temp1_ff};
         tsc_adc_pkg::REG_TAP:   csr_prdata = {16'd0, tap_ff};
         default:                csr_prdata = '0;
      endcase
   end

   assign temp1_reading     = temp1_ff;
   assign tap_release_ticks = tap_ff;

endmodule

// File: design/tsc_adc_queue_ram.sv
module tsc_adc_queue_ram (
   input  logic                            clock,
   input  tsc_adc_pkg::qwr_type            wr,
   input  logic                            rd_en,
   input  logic [tsc_adc_pkg::PTR_W-1:0]   rd_addr,
   output logic [7:0]                      rd_data
);

   // two banks so both bytes of a reading land on the same edge;
   // bank_sel_ff tells which bank holds each slot
   logic [7:0] mem_a_ff [tsc_adc_pkg::QUEUE_DEPTH];
   logic [7:0] mem_b_ff [tsc_adc_pkg::QUEUE_DEPTH];
   logic       bank_sel_ff [tsc_adc_pkg::QUEUE_DEPTH];
   logic [7:0] rd_a_ff;
   logic [7:0] rd_b_ff;
   logic       rd_sel_ff;

   // read-first: a slot freed and refilled on the same edge reads old data
   always_ff @(posedge clock) begin
      if (wr.we0) begin
         mem_a_ff[wr.addr0]    <= wr.data0;
         bank_sel_ff[wr.addr0] <= 1'b0;
      end
      if (wr.we1) begin
         mem_b_ff[wr.addr1]    <= wr.data1;
         bank_sel_ff[wr.addr1] <= 1'b1;
      end
      if (rd_en) begin
         rd_a_ff   <= mem_a_ff[rd_addr];
         rd_b_ff   <= mem_b_ff[rd_addr];
         rd_sel_ff <= bank_sel_ff[rd_addr];
      end
   end

   assign rd_data = rd_sel_ff ? rd_b_ff : rd_a_ff;

endmodule

// File: design/tsc_adc_ctrl.sv
module tsc_adc_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [1:0]                     mode,
   input  logic [7:0]                     spi_byte,
   input  logic                           keep_select,
   input  logic [7:0]                     touch_x,
   input  logic [7:0]                     touch_y,
   input  logic                           pen_down,
   input  logic                           quick_tap,
   input  logic                           move_only,
   input  logic [11:0]                    temp1_reading,
   input  logic [15:0]                    tap_release_ticks,
   output tsc_adc_pkg::qwr_type           wr,
   output logic                           rd_en,
   output logic [tsc_adc_pkg::PTR_W-1:0]  rd_addr,
   output tsc_adc_pkg::s0_info_type       s0
);

   localparam int PW = tsc_adc_pkg::PTR_W;
   localparam int CW = tsc_adc_pkg::CNT_W;
   localparam int SW = tsc_adc_pkg::SUM_W;

   logic [CW-1:0] count_ff, count_in;
   logic [PW-1:0] head_ff, head_in;
   logic          down_ff, down_in;
   logic [11:0]   raw_x_ff, raw_x_in;
   logic [11:0]   raw_y_ff, raw_y_in;
   logic [15:0]   countdown_ff, countdown_in;
   logic          pen_up_ff, pen_up_in;
   logic          select_ff, select_in;

   logic          pop;
   logic [CW-1:0] pop_cnt;
   logic [PW-1:0] head_pop;
   logic [PW-1:0] tail0, tail1;
   logic          start;
   logic          w0, w1;
   logic [2:0]    chan;
   logic [11:0]   v12;
   logic [7:0]    hi_byte, lo_byte;

   assign pop      = (count_ff != '0);
   assign pop_cnt  = count_ff - CW'(pop);
   assign head_pop = pop ? tsc_adc_pkg::wrap_ptr(SW'(head_ff) + SW'(1)) : head_ff;
   assign tail0    = tsc_adc_pkg::wrap_ptr(SW'(head_pop) + SW'(pop_cnt));
   assign tail1    = tsc_adc_pkg::wrap_ptr(SW'(tail0) + SW'(1));
   assign start    = spi_byte[7];
   assign chan     = spi_byte[6:4];
   assign w0       = start && (SW'(pop_cnt) < SW'(tsc_adc_pkg::QUEUE_DEPTH));
   assign w1       = start && ((SW'(pop_cnt) + SW'(1)) < SW'(tsc_adc_pkg::QUEUE_DEPTH));

   // channel reading and its byte split
   always_comb begin
      unique case (chan)
         tsc_adc_pkg::CH_Y:     v12 = down_ff ? raw_y_ff : tsc_adc_pkg::PEN_UP_READING;
         tsc_adc_pkg::CH_X:     v12 = down_ff ? raw_x_ff : 12'd0;
         tsc_adc_pkg::CH_TEMP1: v12 = temp1_reading;
         default:               v12 = 12'd0;
      endcase
      if (chan == tsc_adc_pkg::CH_AUX8) begin
         hi_byte = {1'b0, tsc_adc_pkg::AUX_READING[7:1]};
         lo_byte = {tsc_adc_pkg::AUX_READING[0], 7'd0};
      end else begin
         hi_byte = {1'b0, v12[11:5]};
         lo_byte = {v12[4:0], 3'd0};
      end
   end

   always_comb begin
      count_in     = count_ff;
      head_in      = head_ff;
      down_in      = down_ff;
      raw_x_in     = raw_x_ff;
      raw_y_in     = raw_y_ff;
      countdown_in = countdown_ff;
      pen_up_in    = pen_up_ff;
      select_in    = select_ff;
      wr           = '0;
      rd_en        = 1'b0;
      rd_addr      = head_ff;
      s0           = '0;
      if (accept) begin
         unique case (tsc_adc_pkg::mode_type'(mode))
            tsc_adc_pkg::MODE_SPI: begin
               rd_en       = pop;
               s0.pop      = pop;
               s0.overflow = start && !w1;
               head_in     = head_pop;
               count_in    = pop_cnt + CW'(w0) + CW'(w1);
               wr.we0      = w0;
               wr.addr0    = tail0;
               wr.data0    = hi_byte;
               wr.we1      = w1;
               wr.addr1    = tail1;
               wr.data1    = lo_byte;
               select_in   = keep_select;
            end
            tsc_adc_pkg::MODE_TOUCH: begin
               down_in = pen_down;
               // a move with the pen up only clears the down flag
               if (!(move_only && !pen_down)) begin
                  if (pen_down) begin
                     raw_x_in  = tsc_adc_pkg::clamp_coord(touch_x, tsc_adc_pkg::X_MAX);
                     raw_y_in  = tsc_adc_pkg::clamp_coord(touch_y, tsc_adc_pkg::Y_MAX);
                     pen_up_in = 1'b0;
                  end else begin
                     pen_up_in = 1'b1;
                  end
                  if (quick_tap) countdown_in = tap_release_ticks;
               end
            end
            tsc_adc_pkg::MODE_TICK: begin
               if (countdown_ff != 16'd0) begin
                  countdown_in = countdown_ff - 16'd1;
                  if (countdown_ff == 16'd1) begin
                     down_in   = 1'b0;
                     pen_up_in = 1'b1;
                  end
               end
            end
            tsc_adc_pkg::MODE_SPI_RESET: begin
               select_in = 1'b0;
            end
            default: ;
         endcase
      end
      s0.pen_up = pen_up_in;
      s0.select = select_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         head_ff      <= '0;
         down_ff      <= 1'b0;
         raw_x_ff     <= 12'd0;
         raw_y_ff     <= 12'd0;
         countdown_ff <= 16'd0;
         pen_up_ff    <= 1'b1;
         select_ff    <= 1'b0;
      end else begin
         count_ff     <= count_in;
         head_ff      <= head_in;
         down_ff      <= down_in;
         raw_x_ff     <= raw_x_in;
         raw_y_ff     <= raw_y_in;
         countdown_ff <= countdown_in;
         pen_up_ff    <= pen_up_in;
         select_ff    <= select_in;
      end
   end

endmodule

// File: design/tsc_adc_out.sv
module tsc_adc_out (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  tsc_adc_pkg::s0_info_type  s0,
   input  logic [7:0]                rd_data,
   output logic                      in_ready,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [15:0]               rsp_tdata
);

   logic                     s1_valid_ff;
   tsc_adc_pkg::s0_info_type s1_ff;
   logic                     rsp_valid_ff;
   logic [15:0]              rsp_data_ff;
   logic [7:0]               rr_ff;
   logic [7:0]               rr_new;
   logic                     adv;

   assign adv      = !rsp_valid_ff || rsp_tready;
   assign in_ready = !s1_valid_ff || adv;
   assign rr_new   = s1_ff.pop ? rd_data : rr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rr_ff        <= 8'd0;
      end else begin
         if (in_ready) s1_valid_ff <= accept;
         if (adv) rsp_valid_ff <= s1_valid_ff;
         if (adv && s1_valid_ff) rr_ff <= rr_new;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) s1_ff <= s0;
      if (adv && s1_valid_ff) begin
         rsp_data_ff <= {5'd0, s1_ff.overflow, s1_ff.select, s1_ff.pen_up, rr_new};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: design/tsc_adc_checker.sv
`include "spi_touchscreen_adc_model_unit_assert.svh"

module tsc_adc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [15:0]                        rsp_tdata,
   input logic                               csr_psel,
   input logic                               csr_penable,
   input logic                               csr_pwrite,
   input logic [tsc_adc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input logic [tsc_adc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input logic [tsc_adc_pkg::CSR_DATA_W-1:0] csr_prdata
);

   logic        csr_wr;
   logic        csr_rd;
   logic        wr_temp1;
   logic        wr_tap;
   logic        rd_temp1;
   logic        rd_tap;
   logic        temp1_match;
   logic        tap_match;
   logic [15:0] wdata_ff;

   assign csr_wr      = csr_psel && csr_penable && csr_pwrite;
   assign csr_rd      = csr_psel && !csr_pwrite;
   assign wr_temp1    = csr_wr && (csr_paddr[2] == tsc_adc_pkg::REG_TEMP1);
   assign wr_tap      = csr_wr && (csr_paddr[2] == tsc_adc_pkg::REG_TAP);
   assign rd_temp1    = csr_rd && (csr_paddr[2] == tsc_adc_pkg::REG_TEMP1);
   assign rd_tap      = csr_rd && (csr_paddr[2] == tsc_adc_pkg::REG_TAP);
   // write data of the previous edge
   assign temp1_match = (csr_prdata[11:0] == wdata_ff[11:0]);
   assign tap_match   = (csr_prdata[15:0] == wdata_ff);

   always_ff @(posedge clock) begin
      wdata_ff <= csr_pwdata[15:0];
   end

   `TSC_ASSERT(a_rsp_hold_valid, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid)

   `TSC_ASSERT(a_rsp_hold_data, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))

   `TSC_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_tvalid)

   `TSC_ASSERT(a_temp1_readback, clock, reset, wr_temp1 |=> !rd_temp1 || temp1_match)

   `TSC_ASSERT(a_tap_readback, clock, reset, wr_tap |=> !rd_tap || tap_match)

endmodule

bind spi_touchscreen_adc_model_unit tsc_adc_checker u_tsc_adc_checker (.*);

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

   // response latency allowance of the block
   localparam int LATENCY_CYCLES = 2;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int FIFO_DEPTH     = tsc_adc_pkg::QUEUE_DEPTH;

   // csr byte addresses, register index sits on address bit 2
   localparam logic [tsc_adc_pkg::CSR_ADDR_W-1:0] ADDR_TEMP1 = {tsc_adc_pkg::REG_TEMP1, 2'b00};
   localparam logic [tsc_adc_pkg::CSR_ADDR_W-1:0] ADDR_TAP   = {tsc_adc_pkg::REG_TAP, 2'b00};

   // coordinate clamp limits and fixed readings
   localparam logic [11:0] CLAMP_LOW    = 12'd16;
   localparam logic [11:0] CLAMP_X_HIGH = 12'd4080;
   localparam logic [11:0] CLAMP_Y_HIGH = 12'd3056;
   localparam logic [11:0] Y_PEN_UP     = 12'hFFF;
   localparam logic [7:0]  MIC_READING  = 8'd0;

   typedef struct packed {
      logic [7:0] read_data;
      logic       pen_up_flag;
      logic       select_active;
      logic       queue_overflow;
   } adc_response_type;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_tvalid;
   logic                                 req_tready;
   // req_tdata: spi_byte, keep_select, touch_x, touch_y, pen_down, quick_tap,
   //   move_only, zero fill (lowest bit first)
   logic [31:0]                          req_tdata;
   // req_tuser: mode
   logic [1:0]                           req_tuser;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   // rsp_tdata: read_data, pen_up_flag, select_active, queue_overflow, zero fill
   logic [15:0]                          rsp_tdata;
   logic                                 csr_psel;
   logic                                 csr_penable;
   logic                                 csr_pwrite;
   logic [tsc_adc_pkg::CSR_ADDR_W-1:0]   csr_paddr;
   logic [tsc_adc_pkg::CSR_DATA_W-1:0]   csr_pwdata;
   logic [tsc_adc_pkg::CSR_DATA_W-1:0]   csr_prdata;
   logic                                 csr_pready;

   // shadow of the block state, updated at each accepted request transaction
   logic [7:0]  fifo_mem [FIFO_DEPTH];
   int          fifo_count;
   int          fifo_head;
   logic [7:0]  spi_read_reg;
   logic        pen_down_flag;
   logic [11:0] raw_x;
   logic [11:0] raw_y;
   logic [15:0] release_count;
   logic        pen_up;
   logic        chip_select;
   logic [11:0] temp1_value;
   logic [15:0] tap_ticks;

   // responses predicted but not yet seen, oldest first
   adc_response_type pending_responses[$];

   int failures = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   spi_touchscreen_adc_model_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------

   // append one byte, returns 0 when the fifo was full and the byte dropped
   function automatic logic fifo_push(input logic [7:0] b);
      if (fifo_count >= FIFO_DEPTH) return 1'b0;
      fifo_mem[(fifo_head + fifo_count) % FIFO_DEPTH] = b;
      fifo_count++;
      return 1'b1;
   endfunction

   // pixel to 12-bit reading, shifted up by four and held inside the panel
   function automatic logic [11:0] coord_reading(input logic [7:0] pix,
                                                 input logic [11:0] limit);
      logic [11:0] v;
      v = {pix, 4'b0000};
      if (v < CLAMP_LOW) v = CLAMP_LOW;
      if (v > limit) v = limit;
      return v;
   endfunction

   function automatic void update_touch(input logic [7:0] x, input logic [7:0] y,
                                        input logic down, input logic tap,
                                        input logic moved);
      pen_down_flag = down;
      // a move with the pen lifted only drops the down flag
      if (moved && !down) return;
      if (down) begin
         raw_x  = coord_reading(x, CLAMP_X_HIGH);
         raw_y  = coord_reading(y, CLAMP_Y_HIGH);
         pen_up = 1'b0;
      end else begin
         pen_up = 1'b1;
      end
      if (tap) release_count = tap_ticks;
   endfunction

   // advance the shadow state by one request and return its response
   function automatic adc_response_type next_adc_response(
      input tsc_adc_pkg::mode_type mode,
      input logic [31:0]           data);
      adc_response_type r;
      logic [7:0]       ctrl;
      logic [11:0]      reading;
      logic [7:0]       hi_byte;
      logic [7:0]       lo_byte;
      logic             kept_hi;
      logic             kept_lo;
      logic             dropped;
      dropped = 1'b0;
      ctrl    = data[7:0];
      case (mode)
         tsc_adc_pkg::MODE_SPI: begin
            // oldest byte moves to the read register, empty fifo keeps it
            if (fifo_count != 0) begin
               spi_read_reg = fifo_mem[fifo_head];
               fifo_head    = (fifo_head + 1) % FIFO_DEPTH;
               fifo_count--;
            end
            if (ctrl[7]) begin
               case (ctrl[6:4])
                  tsc_adc_pkg::CH_Y:     reading = pen_down_flag ? raw_y : Y_PEN_UP;
                  tsc_adc_pkg::CH_X:     reading = pen_down_flag ? raw_x : 12'd0;
                  tsc_adc_pkg::CH_TEMP1: reading = temp1_value;
                  default:               reading = 12'd0;
               endcase
               if (ctrl[6:4] == tsc_adc_pkg::CH_AUX8) begin
                  // microphone uses the 8-bit conversion
                  hi_byte = {1'b0, MIC_READING[7:1]};
                  lo_byte = {MIC_READING[0], 7'd0};
               end else begin
                  hi_byte = {1'b0, reading[11:5]};
                  lo_byte = {reading[4:0], 3'd0};
               end
               kept_hi = fifo_push(hi_byte);
               kept_lo = fifo_push(lo_byte);
               dropped = !(kept_hi && kept_lo);
            end
            chip_select = data[8];
         end
         tsc_adc_pkg::MODE_TOUCH: begin
            update_touch(data[16:9], data[24:17], data[25], data[26], data[27]);
         end
         tsc_adc_pkg::MODE_TICK: begin
            if (release_count != 0) begin
               release_count--;
               if (release_count == 0) update_touch(8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
            end
         end
         default: begin
            chip_select = 1'b0;
         end
      endcase
      r.read_data      = spi_read_reg;
      r.pen_up_flag    = pen_up;
      r.select_active  = chip_select;
      r.queue_overflow = dropped;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   function automatic logic [31:0] spi_word(input logic [7:0] ctrl, input logic keep);
      return {23'd0, keep, ctrl};
   endfunction

   function automatic logic [31:0] touch_word(input logic [7:0] x, input logic [7:0] y,
                                              input logic down, input logic tap,
                                              input logic moved);
      return {4'd0, moved, tap, down, y, x, 9'd0};
   endfunction

   // one request transaction; valid stays high afterwards so that
   // back-to-back items see no gap
   task automatic send_request(input tsc_adc_pkg::mode_type mode, input logic [31:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      pending_responses.push_back(next_adc_response(mode, data));
   endtask

   // random request, half of them spi transfers so that the fifo moves around
   task automatic send_random_request();
      int                    pick;
      tsc_adc_pkg::mode_type mode;
      logic [31:0]           data;
      pick = $urandom_range(99);
      if (pick < 50)      mode = tsc_adc_pkg::MODE_SPI;
      else if (pick < 70) mode = tsc_adc_pkg::MODE_TOUCH;
      else if (pick < 90) mode = tsc_adc_pkg::MODE_TICK;
      else                mode = tsc_adc_pkg::MODE_SPI_RESET;
      data = {4'd0, 28'($urandom())};
      // start bit near half, keeps the fifo level wandering between ends
      if (mode == tsc_adc_pkg::MODE_SPI) data[7] = ($urandom_range(99) < 55);
      send_request(mode, data);
   endtask

   // stop sending and let every predicted response come back
   task automatic wait_responses_done();
      req_tvalid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (LATENCY_CYCLES + 2) @(posedge clock);
   endtask

   task automatic csr_write(input logic [tsc_adc_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [tsc_adc_pkg::CSR_DATA_W-1:0] value);
      logic [tsc_adc_pkg::CSR_DATA_W-1:0] readback;
      // setup then access phase, written at the edge closing the access
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == ADDR_TEMP1) temp1_value = value[11:0];
      else                    tap_ticks   = value[15:0];
      // read back through the same port
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== value) begin
         $error("csr readback at %0h: expected %0h, got %0h", addr, value, readback);
         failures++;
      end
      // bus left idle before the next transfer
      @(posedge clock);
   endtask

   task automatic set_registers(input logic [11:0] temp1, input logic [15:0] ticks);
      wait_responses_done();
      csr_write(ADDR_TEMP1, tsc_adc_pkg::CSR_DATA_W'(temp1));
      csr_write(ADDR_TAP, tsc_adc_pkg::CSR_DATA_W'(ticks));
   endtask

   task automatic run_random(input int count, input int send_pct, input int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      repeat (count) send_random_request();
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // y, x, microphone, temperature and a zero channel, empty fifo reads, spi reset and an idle tick
   task automatic test_channel_reads();
      send_request(tsc_adc_pkg::MODE_SPI, spi_word(8'h00, 1'b1));  // empty fifo, no start
      send_request(tsc_adc_pkg::MODE_SPI_RESET, 32'h0FFF_FFFF);    // drops select
      send_request(tsc_adc_pkg::MODE_TICK, 32'h0FFF_FFFF);         // countdown idle
      send_request(tsc_adc_pkg::MODE_SPI, spi_word(8'h90, 1'b0));  // y with pen up
      send_request(tsc_adc_pkg::MODE_SPI, spi_word(8'hD0, 1'b1));  // x with pen up
      send_request(tsc_adc_pkg::MODE_TOUCH, touch_word(8'h00, 8'hFF, 1'b1, 1'b0, 1'b0));
      send_request(tsc_adc_pkg::MODE_SPI, spi_word(8'h9F, 1'b1));  // y, clamped high
      send_request(tsc_adc_pkg::MODE_SPI, spi_word(8'hD0, 1'b0));  // x, clamped low
      send_request(tsc_adc_pkg::MODE_SPI, spi_word(8'hE0, 1'b1));  // 8-bit microphone
      send_request(tsc_adc_pkg::MODE_SPI, spi_word(8'hF0, 1'b1));  // temperature
      send_request(tsc_adc_pkg::MODE_SPI, spi_word(8'hA0, 1'b1));  // zero channel
   endtask

   // fifo is full now: each pop frees one slot, so the high byte is kept
   // and the low byte dropped
   task automatic test_fifo_overflow();
      send_request(tsc_adc_pkg::MODE_SPI, spi_word(8'hB0, 1'b1));
      send_request(tsc_adc_pkg::MODE_SPI, spi_word(8'hC0, 1'b1));
      send_request(tsc_adc_pkg::MODE_SPI, spi_word(8'hFF, 1'b1));
      send_request(tsc_adc_pkg::MODE_SPI, spi_word(8'h7F, 1'b0));
   endtask

   // coordinate clamps, moves, tap countdown with zero and short reloads
   task automatic test_touch_release();
      send_request(tsc_adc_pkg::MODE_TOUCH, touch_word(8'hFF, 8'h00, 1'b1, 1'b1, 1'b1));
      send_request(tsc_adc_pkg::MODE_TOUCH, touch_word(8'h00, 8'h00, 1'b0, 1'b0, 1'b1));
      send_request(tsc_adc_pkg::MODE_SPI, spi_word(8'hD0, 1'b1));  // x after down cleared
      send_request(tsc_adc_pkg::MODE_TOUCH, touch_word(8'h07, 8'h64, 1'b0, 1'b1, 1'b0));
      send_request(tsc_adc_pkg::MODE_TICK, 32'd0);
      // zero ticks: a tap arms nothing
      set_registers(12'd142, 16'd0);
      send_request(tsc_adc_pkg::MODE_TOUCH, touch_word(8'h0C, 8'h22, 1'b1, 1'b1, 1'b0));
      send_request(tsc_adc_pkg::MODE_TICK, 32'd0);
      send_request(tsc_adc_pkg::MODE_TICK, 32'd0);
      // two ticks release the pen
      set_registers(12'hFFF, 16'd2);
      send_request(tsc_adc_pkg::MODE_TOUCH, touch_word(8'hC8, 8'hBF, 1'b1, 1'b1, 1'b0));
      send_request(tsc_adc_pkg::MODE_TICK, 32'd0);
      send_request(tsc_adc_pkg::MODE_TICK, 32'd0);
      send_request(tsc_adc_pkg::MODE_SPI, spi_word(8'hF0, 1'b0));
   endtask

   task automatic test_random_no_idle();
      set_registers(12'($urandom()), 16'($urandom_range(12, 1)));
      run_random(112, 0, 0);
   endtask

   task automatic test_random_sender_idle();
      set_registers(12'd0, 16'hFFFF);
      run_random(112, 66, 0);
   endtask

   task automatic test_random_receiver_stall();
      set_registers(12'($urandom()), 16'($urandom_range(12, 1)));
      run_random(56, 0, 66);
      // hold off until the block has answered everything, then resume
      wait_responses_done();
      run_random(56, 0, 66);
   endtask

   task automatic test_random_both_idle();
      set_registers(12'($urandom()), 16'd3);
      run_random(112, 20, 20);
   endtask

   // ---------------------------------------------------------------------
   // response side
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // compare each response transaction with the oldest prediction
   always @(posedge clock) begin
      adc_response_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_responses.size() == 0) begin
            $error("response with none pending: %0h", rsp_tdata);
            failures++;
         end else begin
            want = pending_responses.pop_front();
            if (rsp_tdata[7:0] !== want.read_data) begin
               $error("read_data: expected %0h, got %0h", want.read_data, rsp_tdata[7:0]);
               failures++;
            end
            if (rsp_tdata[8] !== want.pen_up_flag) begin
               $error("pen_up_flag: expected %0b, got %0b", want.pen_up_flag, rsp_tdata[8]);
               failures++;
            end
            if (rsp_tdata[9] !== want.select_active) begin
               $error("select_active: expected %0b, got %0b", want.select_active,
                      rsp_tdata[9]);
               failures++;
            end
            if (rsp_tdata[10] !== want.queue_overflow) begin
               $error("queue_overflow: expected %0b, got %0b", want.queue_overflow,
                      rsp_tdata[10]);
               failures++;
            end
         end
      end
   end

   // watchdog on the whole run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = tsc_adc_pkg::MODE_SPI;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;

      // shadow state as after reset
      foreach (fifo_mem[i]) fifo_mem[i] = 8'd0;
      fifo_count    = 0;
      fifo_head     = 0;
      spi_read_reg  = 8'd0;
      pen_down_flag = 1'b0;
      raw_x         = 12'd0;
      raw_y         = 12'd0;
      release_count = 16'd0;
      pen_up        = 1'b1;
      chip_select   = 1'b0;
      temp1_value   = 12'd142;
      tap_ticks     = 16'd512;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_channel_reads();
      test_fifo_overflow();
      test_touch_release();
      test_random_no_idle();
      test_random_sender_idle();
      test_random_receiver_stall();
      test_random_both_idle();

      wait_responses_done();
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
